// ===== src/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the ellipse edge clipper pipeline.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int CoordBits = 16;
  localparam int DimBits   = 15;
  localparam int DeltaBits = CoordBits + 1;
  localparam int OutBits   = CoordBits + 1;
  localparam int FracBits  = 16;
  localparam int SqBits    = 64;
  localparam int RootBits  = SqBits / 2;
  localparam int NumBits   = 2 * DimBits + DeltaBits;
  localparam int ShBits    = 5;
  localparam int RootCells = RootBits;
  localparam int DivCells  = RootBits;

  typedef enum logic [1:0] {
    MODE_CENTER,
    MODE_VERT,
    MODE_CLIP
  } ecc_mode_e;

  typedef struct packed {
    logic                        valid;
    ecc_mode_e                   mode;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic [DimBits-1:0]          h;
    logic                        neg_x;
    logic                        neg_y;
  } ecc_side_t;

  typedef struct packed {
    ecc_side_t           side;
    logic [SqBits-1:0]   v;
    logic [SqBits-1:0]   r;
    logic [NumBits-1:0]  num_x;
    logic [NumBits-1:0]  num_y;
    logic [ShBits-1:0]   k;
  } ecc_sq_t;

  typedef struct packed {
    ecc_side_t           side;
    logic [RootBits-1:0] divisor;
    logic [RootBits-1:0] rem_x;
    logic [RootBits-1:0] lq_x;
    logic [RootBits-1:0] rem_y;
    logic [RootBits-1:0] lq_y;
  } ecc_dv_t;

endpackage

// ===== src/ecc_front.sv =====
// ----------------------------------------------------------------------------
// ecc_front
// Front end: deltas, products, the radicand, the inside test and its scaling.
// ----------------------------------------------------------------------------
module ecc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] center_x_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] center_y_i,
  input  logic [ecc_pkg::DimBits-1:0]         box_width_i,
  input  logic [ecc_pkg::DimBits-1:0]         box_height_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] target_x_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] target_y_i,
  output ecc_pkg::ecc_sq_t                    sq_o
);
  import ecc_pkg::*;

  // Stage 1: registered inputs and signed deltas.
  logic                        s1_vld_q;
  logic signed [CoordBits-1:0] s1_cx_q, s1_cy_q;
  logic [DimBits-1:0]          s1_w_q, s1_h_q;
  logic signed [DeltaBits-1:0] s1_dx_q, s1_dy_q;

  // Stage 2: magnitudes and first products.
  logic                        s2_vld_q;
  logic signed [CoordBits-1:0] s2_cx_q, s2_cy_q;
  logic [DimBits-1:0]          s2_h_q;
  logic                        s2_negx_q, s2_negy_q, s2_dxz_q;
  logic [DeltaBits-1:0]        s2_adx_q, s2_ady_q;
  logic [DimBits+DeltaBits-1:0] s2_hx_q, s2_wy_q;
  logic [2*DimBits-1:0]        s2_wh_q;

  // Stage 3: squares and numerators.
  logic                        s3_vld_q;
  logic signed [CoordBits-1:0] s3_cx_q, s3_cy_q;
  logic [DimBits-1:0]          s3_h_q;
  logic                        s3_negx_q, s3_negy_q, s3_dxz_q;
  logic [SqBits-1:0]           s3_hx2_q, s3_wy2_q;
  logic [4*DimBits-1:0]        s3_whsq_q;
  logic [NumBits-1:0]          s3_numx_q, s3_numy_q;

  // Stage 4: radicand, case selection and scale.
  ecc_side_t                   s4_side_q;
  logic [SqBits-1:0]           s4_s_q;
  logic [ShBits-1:0]           s4_k_q;
  logic [NumBits-1:0]          s4_numx_q, s4_numy_q;

  logic [DeltaBits-1:0] adx_d, ady_d;
  logic [SqBits-1:0]    s_d;
  logic                 inside_d;
  logic [ShBits-1:0]    k_d;
  ecc_side_t            side_d;

  assign adx_d = s1_dx_q[DeltaBits-1] ? DeltaBits'(-s1_dx_q) : DeltaBits'(s1_dx_q);
  assign ady_d = s1_dy_q[DeltaBits-1] ? DeltaBits'(-s1_dy_q) : DeltaBits'(s1_dy_q);

  assign s_d      = s3_hx2_q + s3_wy2_q;
  assign inside_d = {s_d, 2'b00} < {(SqBits + 2 - 4 * DimBits)'(0), s3_whsq_q};

  // Largest scale k (up to the fraction width) with s * 4^k still in 64 bits.
  always_comb begin
    k_d = '0;
    for (int i = 1; i <= FracBits; i++) begin
      if ((s_d >> (SqBits - 2 * i)) == '0) begin
        k_d = ShBits'(i);
      end
    end
  end

  always_comb begin
    side_d.valid = s3_vld_q;
    side_d.cx    = s3_cx_q;
    side_d.cy    = s3_cy_q;
    side_d.h     = s3_h_q;
    side_d.neg_x = s3_negx_q;
    side_d.neg_y = s3_negy_q;
    if (inside_d) begin
      side_d.mode = MODE_CENTER;
    end else if (s3_dxz_q) begin
      side_d.mode = MODE_VERT;
    end else if (s_d != '0) begin
      side_d.mode = MODE_CLIP;
    end else begin
      side_d.mode = MODE_CENTER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q       <= 1'b0;
      s2_vld_q       <= 1'b0;
      s3_vld_q       <= 1'b0;
      s4_side_q      <= '0;
      sq_o           <= '0;
    end else begin
      s1_vld_q       <= accept_i;
      s2_vld_q       <= s1_vld_q;
      s3_vld_q       <= s2_vld_q;
      s4_side_q      <= side_d;
      sq_o.side      <= s4_side_q;
      sq_o.v         <= s4_s_q << {s4_k_q, 1'b0};
      sq_o.r         <= '0;
      sq_o.num_x     <= s4_numx_q;
      sq_o.num_y     <= s4_numy_q;
      sq_o.k         <= s4_k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cx_q   <= center_x_i;
    s1_cy_q   <= center_y_i;
    s1_w_q    <= box_width_i;
    s1_h_q    <= box_height_i;
    s1_dx_q   <= DeltaBits'(target_x_i) - DeltaBits'(center_x_i);
    s1_dy_q   <= DeltaBits'(target_y_i) - DeltaBits'(center_y_i);

    s2_cx_q   <= s1_cx_q;
    s2_cy_q   <= s1_cy_q;
    s2_h_q    <= s1_h_q;
    s2_negx_q <= s1_dx_q[DeltaBits-1];
    s2_negy_q <= s1_dy_q[DeltaBits-1];
    s2_dxz_q  <= (s1_dx_q == '0);
    s2_adx_q  <= adx_d;
    s2_ady_q  <= ady_d;
    s2_hx_q   <= (DimBits+DeltaBits)'(s1_h_q) * (DimBits+DeltaBits)'(adx_d);
    s2_wy_q   <= (DimBits+DeltaBits)'(s1_w_q) * (DimBits+DeltaBits)'(ady_d);
    s2_wh_q   <= (2*DimBits)'(s1_w_q) * (2*DimBits)'(s1_h_q);

    s3_cx_q   <= s2_cx_q;
    s3_cy_q   <= s2_cy_q;
    s3_h_q    <= s2_h_q;
    s3_negx_q <= s2_negx_q;
    s3_negy_q <= s2_negy_q;
    s3_dxz_q  <= s2_dxz_q;
    s3_hx2_q  <= SqBits'(s2_hx_q) * SqBits'(s2_hx_q);
    s3_wy2_q  <= SqBits'(s2_wy_q) * SqBits'(s2_wy_q);
    s3_whsq_q <= (4 * DimBits)'(s2_wh_q) * (4 * DimBits)'(s2_wh_q);
    s3_numx_q <= NumBits'(s2_wh_q) * NumBits'(s2_adx_q);
    s3_numy_q <= NumBits'(s2_wh_q) * NumBits'(s2_ady_q);

    s4_s_q    <= s_d;
    s4_k_q    <= k_d;
    s4_numx_q <= s3_numx_q;
    s4_numy_q <= s3_numy_q;
  end

endmodule

// ===== src/ecc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ecc_sqrt_cell
// One digit of the integer square root: settles one root bit per cell.
// ----------------------------------------------------------------------------
module ecc_sqrt_cell #(
  parameter int unsigned POS = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ecc_pkg::ecc_sq_t sq_i,
  output ecc_pkg::ecc_sq_t sq_o
);
  import ecc_pkg::*;

  localparam logic [SqBits-1:0] BitVal = SqBits'(1) << (2 * POS);

  logic [SqBits-1:0] trial;
  ecc_sq_t           sq_d;

  assign trial = sq_i.r + BitVal;

  always_comb begin
    sq_d = sq_i;
    if (sq_i.v >= trial) begin
      sq_d.v = sq_i.v - trial;
      sq_d.r = (sq_i.r >> 1) + BitVal;
    end else begin
      sq_d.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_o <= '0;
    end else begin
      sq_o <= sq_d;
    end
  end

endmodule

// ===== src/ecc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ecc_div_cell
// One restoring division step for both offset lanes against the shared root.
// ----------------------------------------------------------------------------
module ecc_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ecc_pkg::ecc_dv_t dv_i,
  output ecc_pkg::ecc_dv_t dv_o
);
  import ecc_pkg::*;

  logic [RootBits:0] t_x, t_y;
  logic              ge_x, ge_y;
  ecc_dv_t           dv_d;

  // Shift the next dividend bit into the partial remainder, then try a subtract.
  assign t_x  = {dv_i.rem_x, dv_i.lq_x[RootBits-1]};
  assign t_y  = {dv_i.rem_y, dv_i.lq_y[RootBits-1]};
  assign ge_x = t_x >= {1'b0, dv_i.divisor};
  assign ge_y = t_y >= {1'b0, dv_i.divisor};

  always_comb begin
    dv_d       = dv_i;
    dv_d.rem_x = ge_x ? RootBits'(t_x - {1'b0, dv_i.divisor}) : t_x[RootBits-1:0];
    dv_d.rem_y = ge_y ? RootBits'(t_y - {1'b0, dv_i.divisor}) : t_y[RootBits-1:0];
    dv_d.lq_x  = {dv_i.lq_x[RootBits-2:0], ge_x};
    dv_d.lq_y  = {dv_i.lq_y[RootBits-2:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_o <= '0;
    end else begin
      dv_o <= dv_d;
    end
  end

endmodule

// ===== src/ecc_back.sv =====
// ----------------------------------------------------------------------------
// ecc_back
// Output stage: centre plus offsets or half height, truncated toward zero.
// ----------------------------------------------------------------------------
module ecc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ecc_pkg::ecc_dv_t                   dv_i,
  output logic                               done_o,
  output logic signed [ecc_pkg::OutBits-1:0] edge_x_o,
  output logic signed [ecc_pkg::OutBits-1:0] edge_y_o
);
  import ecc_pkg::*;

  localparam int VBits = CoordBits + FracBits + 2;

  logic signed [VBits-1:0]       base_x, base_y, off_x, off_y, vx, vy;
  logic signed [VBits-FracBits-1:0] qx, qy;
  logic signed [OutBits:0]       vv, qv;
  logic signed [OutBits-1:0]     ex_d, ey_d;

  assign base_x = {{2{dv_i.side.cx[CoordBits-1]}}, dv_i.side.cx, FracBits'(0)};
  assign base_y = {{2{dv_i.side.cy[CoordBits-1]}}, dv_i.side.cy, FracBits'(0)};
  assign off_x  = {2'b00, dv_i.lq_x};
  assign off_y  = {2'b00, dv_i.lq_y};
  assign vx     = dv_i.side.neg_x ? base_x - off_x : base_x + off_x;
  assign vy     = dv_i.side.neg_y ? base_y - off_y : base_y + off_y;

  // Floor by the shift, then step back up for negative values with a fraction.
  assign qx = vx[VBits-1:FracBits]
            + (VBits-FracBits)'(vx[VBits-1] && (vx[FracBits-1:0] != '0));
  assign qy = vy[VBits-1:FracBits]
            + (VBits-FracBits)'(vy[VBits-1] && (vy[FracBits-1:0] != '0));

  // Straight above or below: half the height off the centre.
  assign vv = dv_i.side.neg_y
            ? {dv_i.side.cy[CoordBits-1], dv_i.side.cy, 1'b0} - (OutBits+1)'(dv_i.side.h)
            : {dv_i.side.cy[CoordBits-1], dv_i.side.cy, 1'b0} + (OutBits+1)'(dv_i.side.h);
  assign qv = {vv[OutBits], vv[OutBits:1]} + (OutBits+1)'(vv[OutBits] && vv[0]);

  always_comb begin
    case (dv_i.side.mode)
      MODE_VERT: begin
        ex_d = {dv_i.side.cx[CoordBits-1], dv_i.side.cx};
        ey_d = qv[OutBits-1:0];
      end
      MODE_CLIP: begin
        ex_d = qx[OutBits-1:0];
        ey_d = qy[OutBits-1:0];
      end
      default: begin
        ex_d = {dv_i.side.cx[CoordBits-1], dv_i.side.cx};
        ey_d = {dv_i.side.cy[CoordBits-1], dv_i.side.cy};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_i.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_x_o <= ex_d;
    edge_y_o <= ey_d;
  end

endmodule

// ===== src/ellipse_edge_clip_top.sv =====
// ----------------------------------------------------------------------------
// ellipse_edge_clip_top
// Clips the line from an ellipse centre toward a target at the ellipse edge.
// ----------------------------------------------------------------------------
// A transaction is accepted on every rising edge with start high and busy low.
// The block never stalls, so busy stays low and a new transaction can be
// issued on every clock cycle; throughput is one transaction per cycle.
// The result appears on edge_x_o and edge_y_o for exactly one cycle, marked
// by done_o. It passes a chain of registers: five front-end stages (deltas,
// products, squares, radicand and inside test, scaling), 32 square-root
// cells that each settle one root bit, one stage that aligns the two
// dividends, 32 division cells that each settle one quotient bit of both
// offsets, and one output register. Transactions leave in the order they
// entered. The receiver cannot hold results off; done_o must be consumed in
// the cycle it is shown.
// Reset is asynchronous and active low; it empties the pipeline so no
// strobe appears until new transactions arrive. Nothing is stored across
// transactions, so there is no configuration and no clearing pass.
// ----------------------------------------------------------------------------
module ellipse_edge_clip_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ecc_pkg::CoordBits-1:0] center_x_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] center_y_i,
  input  logic [ecc_pkg::DimBits-1:0]         box_width_i,
  input  logic [ecc_pkg::DimBits-1:0]         box_height_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] target_x_i,
  input  logic signed [ecc_pkg::CoordBits-1:0] target_y_i,
  output logic                                done_o,
  output logic signed [ecc_pkg::OutBits-1:0]  edge_x_o,
  output logic signed [ecc_pkg::OutBits-1:0]  edge_y_o
);
  import ecc_pkg::*;

  ecc_sq_t sq_w [0:RootCells];
  ecc_dv_t dv_w [0:DivCells];
  ecc_dv_t load_d;
  logic    accept;

  // The pipeline always advances, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ecc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .box_width_i (box_width_i),
    .box_height_i(box_height_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .sq_o        (sq_w[0])
  );

  // Square root chain: the first cell handles the top root bit.
  for (genvar j = 0; j < RootCells; j++) begin : g_sqrt
    ecc_sqrt_cell #(
      .POS(RootCells - 1 - j)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .sq_i  (sq_w[j]),
      .sq_o  (sq_w[j+1])
    );
  end

  // Dividend alignment. Each numerator is scaled by 2^(15+k); the quotient
  // is known to fit in 32 bits, so the upper half of the dividend is already
  // smaller than the root and serves as the starting remainder.
  logic [SqBits-1:0] dvd_x, dvd_y;
  logic [ShBits:0]   dvd_sh;

  assign dvd_sh = (ShBits+1)'(FracBits - 1) + (ShBits+1)'(sq_w[RootCells].k);
  assign dvd_x  = SqBits'(sq_w[RootCells].num_x) << dvd_sh;
  assign dvd_y  = SqBits'(sq_w[RootCells].num_y) << dvd_sh;

  always_comb begin
    load_d.side    = sq_w[RootCells].side;
    load_d.divisor = sq_w[RootCells].r[RootBits-1:0];
    load_d.rem_x   = dvd_x[SqBits-1:RootBits];
    load_d.lq_x    = dvd_x[RootBits-1:0];
    load_d.rem_y   = dvd_y[SqBits-1:RootBits];
    load_d.lq_y    = dvd_y[RootBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_w[0] <= '0;
    end else begin
      dv_w[0] <= load_d;
    end
  end

  // Division chain: both offsets share the root as divisor.
  for (genvar j = 0; j < DivCells; j++) begin : g_div
    ecc_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .dv_i  (dv_w[j]),
      .dv_o  (dv_w[j+1])
    );
  end

  ecc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dv_i    (dv_w[DivCells]),
    .done_o  (done_o),
    .edge_x_o(edge_x_o),
    .edge_y_o(edge_y_o)
  );

  // A clipped transaction needs a nonzero root and a starting remainder below it.
  a_div_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_d.side.valid && load_d.side.mode == MODE_CLIP) |->
      (load_d.divisor != '0 && load_d.rem_x < load_d.divisor &&
       load_d.rem_y < load_d.divisor))
    else $error("division chain loaded with an out-of-range remainder");

  // Every strobe comes from a live transaction at the end of the division chain.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dv_w[DivCells].side.valid))
    else $error("result strobe without a transaction behind it");

  // A target inside the ellipse gives the centre; the check covers the x coordinate.
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(dv_w[DivCells].side.valid && dv_w[DivCells].side.mode == MODE_CENTER) |->
      (done_o && edge_x_o == {$past(dv_w[DivCells].side.cx[CoordBits-1]),
                              $past(dv_w[DivCells].side.cx)}))
    else $error("centre case did not return the centre");

endmodule
